// ----- design/lgac_pkg.sv -----
// Shared types, constants and bit search helpers for the longest gap after cuts block.
package lgac_pkg;

  // Width of every length and position on the ports.
  localparam int LEN_W = 13;
  // Line length taken at reset before saturation.
  localparam int RESET_LENGTH = 4096;
  // The cut map is stored as words of this many positions.
  localparam int WORD_W = 32;
  localparam int BIT_W = $clog2(WORD_W);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SEED,
    ST_IDLE,
    ST_HOME,
    ST_LSCAN,
    ST_RSTART,
    ST_RSCAN,
    ST_SPLIT_RD,
    ST_SPLIT_WR,
    ST_LO_RD,
    ST_LO_WR,
    ST_HI_RD,
    ST_HI_WR,
    ST_WALK0,
    ST_WALK
  } state_t;

  // Index of the highest set bit; zero when no bit is set.
  function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage

// ----- design/lgac_ram.sv -----
// Generic simple dual port RAM with one write port and a registered read port.
module lgac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- design/longest_gap_after_cuts_core.sv -----
// Top level of the longest gap after cuts block: sequencer around the cut map and gap count RAMs.
//
// Each item tries to place one cut and returns one result on done, longest_gap and rejected, one
// cycle wide; the receiver cannot stall, so a result is simply presented and gone. A position
// that is zero or not below the line length is answered in the cycle after it is taken, and a
// position that is already cut is answered from ST_HOME, after its cut map read. Any other item
// reads its cut map word (32 positions per read), searches for the nearest cut below and above
// one word per cycle, updates the gap count RAM with a read and a write each for the split gap,
// the low part and the high part, and then walks the longest length down at one count RAM read
// per cycle. The neighbor search grows with the distance to the nearest cuts in words, and the
// walk of the longest length adds at most line_length steps over all cuts between two writes of
// the length. After reset and after every write of line_length the block clears both RAMs, one
// entry a cycle, and then seeds the full line length as the one gap, with busy high.
module longest_gap_after_cuts_core #(
  parameter int MAX_LINE_LENGTH = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [lgac_pkg::LEN_W-1:0] cut_position,
  input  logic                    line_length_wr,
  input  logic [lgac_pkg::LEN_W-1:0] line_length,
  output logic                    done,
  output logic [lgac_pkg::LEN_W-1:0] longest_gap,
  output logic                    rejected
);
  import lgac_pkg::*;

  localparam int CNT_DEPTH = MAX_LINE_LENGTH + 1;
  localparam int CAW = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
  localparam int MAP_DEPTH = (MAX_LINE_LENGTH + WORD_W) / WORD_W;
  localparam int MAW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  state_t state, state_next;

  logic [LEN_W-1:0]  line_len_q, line_len_next;
  logic [LEN_W-1:0]  cur_longest, cur_longest_next;
  logic [CAW-1:0]    clr_addr, clr_addr_next;
  logic [LEN_W-1:0]  pos, pos_next;
  logic [LEN_W-1:0]  left_pos, left_pos_next;
  logic [LEN_W-1:0]  right_pos, right_pos_next;
  logic [MAW-1:0]    scan_idx, scan_idx_next;
  logic [WORD_W-1:0] home_word, home_word_next;
  logic [LEN_W-1:0]  probe, probe_next;
  logic [LEN_W-1:0]  probe_q, probe_q_next;
  logic              done_next, rejected_next;
  logic [LEN_W-1:0]  longest_gap_next;

  logic              map_we;
  logic [MAW-1:0]    map_waddr, map_raddr;
  logic [WORD_W-1:0] map_wdata, map_rdata;
  logic              cnt_we;
  logic [CAW-1:0]    cnt_waddr, cnt_raddr;
  logic [LEN_W-1:0]  cnt_wdata, cnt_rdata;

  logic [LEN_W-1:0]  cfg_len;
  logic [MAW-1:0]    home_idx;
  logic [BIT_W-1:0]  home_bit;
  logic [WORD_W-1:0] below_mask, above_mask;
  logic [WORD_W-1:0] map_below, home_above;
  logic              past_end;

  // Saturate the written length into 1..MAX_LINE_LENGTH.
  always_comb begin
    if (line_length == '0) begin
      cfg_len = LEN_W'(1);
    end else if (32'(line_length) > MAX_LINE_LENGTH) begin
      cfg_len = LEN_W'(MAX_LINE_LENGTH);
    end else begin
      cfg_len = line_length;
    end
  end

  assign home_idx   = MAW'(pos >> BIT_W);
  assign home_bit   = pos[BIT_W-1:0];
  assign below_mask = (WORD_W'(1) << home_bit) - WORD_W'(1);
  assign above_mask = ~((WORD_W'(2) << home_bit) - WORD_W'(1));
  assign map_below  = map_rdata & below_mask;
  assign home_above = home_word & above_mask;
  // The word at scan_idx is the last one that can hold a cut below the line end.
  assign past_end   = ((32'(scan_idx) + 1) << BIT_W) >= 32'(line_len_q);

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next       = state;
    line_len_next    = line_len_q;
    cur_longest_next = cur_longest;
    clr_addr_next    = clr_addr;
    pos_next         = pos;
    left_pos_next    = left_pos;
    right_pos_next   = right_pos;
    scan_idx_next    = scan_idx;
    home_word_next   = home_word;
    probe_next       = probe;
    probe_q_next     = probe_q;
    done_next        = 1'b0;
    rejected_next    = rejected;
    longest_gap_next = longest_gap;
    map_we           = 1'b0;
    map_waddr        = home_idx;
    map_wdata        = '0;
    map_raddr        = home_idx;
    cnt_we           = 1'b0;
    cnt_waddr        = clr_addr;
    cnt_wdata        = '0;
    cnt_raddr        = CAW'(probe);

    case (state)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        map_we    = (32'(clr_addr) < MAP_DEPTH);
        map_waddr = MAW'(clr_addr);
        if (32'(clr_addr) == MAX_LINE_LENGTH) begin
          state_next = ST_SEED;
        end else begin
          clr_addr_next = clr_addr + CAW'(1);
        end
      end
      ST_SEED: begin
        cnt_we           = 1'b1;
        cnt_waddr        = CAW'(line_len_q);
        cnt_wdata        = LEN_W'(1);
        cur_longest_next = line_len_q;
        state_next       = ST_IDLE;
      end
      ST_IDLE: begin
        map_raddr = MAW'(cut_position >> BIT_W);
        if (start) begin
          pos_next = cut_position;
          if (cut_position == '0 || cut_position >= line_len_q) begin
            done_next        = 1'b1;
            rejected_next    = 1'b1;
            longest_gap_next = cur_longest;
          end else begin
            state_next = ST_HOME;
          end
        end
      end
      ST_HOME: begin
        home_word_next = map_rdata;
        if (map_rdata[home_bit]) begin
          // Already cut: nothing changes.
          done_next        = 1'b1;
          rejected_next    = 1'b1;
          longest_gap_next = cur_longest;
          state_next       = ST_IDLE;
        end else if (map_below != '0) begin
          left_pos_next = LEN_W'({home_idx, top_bit(map_below)});
          state_next    = ST_RSTART;
        end else if (home_idx == '0) begin
          left_pos_next = '0;
          state_next    = ST_RSTART;
        end else begin
          map_raddr     = home_idx - MAW'(1);
          scan_idx_next = home_idx - MAW'(1);
          state_next    = ST_LSCAN;
        end
      end
      ST_LSCAN: begin
        if (map_rdata != '0) begin
          left_pos_next = LEN_W'({scan_idx, top_bit(map_rdata)});
          state_next    = ST_RSTART;
        end else if (scan_idx == '0) begin
          left_pos_next = '0;
          state_next    = ST_RSTART;
        end else begin
          map_raddr     = scan_idx - MAW'(1);
          scan_idx_next = scan_idx - MAW'(1);
        end
      end
      ST_RSTART: begin
        scan_idx_next = home_idx;
        if (home_above != '0) begin
          right_pos_next = LEN_W'({home_idx, low_bit(home_above)});
          state_next     = ST_SPLIT_RD;
        end else if (((32'(home_idx) + 1) << BIT_W) >= 32'(line_len_q)) begin
          right_pos_next = line_len_q;
          state_next     = ST_SPLIT_RD;
        end else begin
          map_raddr     = home_idx + MAW'(1);
          scan_idx_next = home_idx + MAW'(1);
          state_next    = ST_RSCAN;
        end
      end
      ST_RSCAN: begin
        if (map_rdata != '0) begin
          right_pos_next = LEN_W'({scan_idx, low_bit(map_rdata)});
          state_next     = ST_SPLIT_RD;
        end else if (past_end) begin
          right_pos_next = line_len_q;
          state_next     = ST_SPLIT_RD;
        end else begin
          map_raddr     = scan_idx + MAW'(1);
          scan_idx_next = scan_idx + MAW'(1);
        end
      end
      ST_SPLIT_RD: begin
        map_we     = 1'b1;
        map_wdata  = home_word | (WORD_W'(1) << home_bit);
        cnt_raddr  = CAW'(right_pos - left_pos);
        state_next = ST_SPLIT_WR;
      end
      ST_SPLIT_WR: begin
        cnt_waddr  = CAW'(right_pos - left_pos);
        cnt_we     = (cnt_rdata != '0);
        cnt_wdata  = cnt_rdata - LEN_W'(1);
        state_next = ST_LO_RD;
      end
      ST_LO_RD: begin
        cnt_raddr  = CAW'(pos - left_pos);
        state_next = ST_LO_WR;
      end
      ST_LO_WR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = CAW'(pos - left_pos);
        cnt_wdata  = cnt_rdata + LEN_W'(1);
        state_next = ST_HI_RD;
      end
      ST_HI_RD: begin
        cnt_raddr  = CAW'(right_pos - pos);
        state_next = ST_HI_WR;
      end
      ST_HI_WR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = CAW'(right_pos - pos);
        cnt_wdata  = cnt_rdata + LEN_W'(1);
        probe_next = cur_longest;
        state_next = ST_WALK0;
      end
      ST_WALK0: begin
        cnt_raddr    = CAW'(probe);
        probe_q_next = probe;
        probe_next   = (probe > LEN_W'(1)) ? probe - LEN_W'(1) : probe;
        state_next   = ST_WALK;
      end
      ST_WALK: begin
        // One candidate length is probed per cycle; the read for the next one is already out.
        if (cnt_rdata != '0 || probe_q <= LEN_W'(1)) begin
          cur_longest_next = probe_q;
          done_next        = 1'b1;
          rejected_next    = 1'b0;
          longest_gap_next = probe_q;
          state_next       = ST_IDLE;
        end else begin
          cnt_raddr    = CAW'(probe);
          probe_q_next = probe;
          probe_next   = (probe > LEN_W'(1)) ? probe - LEN_W'(1) : probe;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase

    if (line_length_wr) begin
      line_len_next = cfg_len;
      clr_addr_next = '0;
      state_next    = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      done        <= 1'b0;
      cur_longest <= (RESET_LENGTH > MAX_LINE_LENGTH) ? LEN_W'(MAX_LINE_LENGTH)
                                                      : LEN_W'(RESET_LENGTH);
      line_len_q  <= (RESET_LENGTH > MAX_LINE_LENGTH) ? LEN_W'(MAX_LINE_LENGTH)
                                                      : LEN_W'(RESET_LENGTH);
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      done        <= done_next;
      cur_longest <= cur_longest_next;
      line_len_q  <= line_len_next;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    left_pos    <= left_pos_next;
    right_pos   <= right_pos_next;
    scan_idx    <= scan_idx_next;
    home_word   <= home_word_next;
    probe       <= probe_next;
    probe_q     <= probe_q_next;
    rejected    <= rejected_next;
    longest_gap <= longest_gap_next;
  end

  lgac_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAP_DEPTH)
  ) u_cut_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .raddr(map_raddr),
    .rdata(map_rdata)
  );

  lgac_ram #(
    .WIDTH(LEN_W),
    .DEPTH(CNT_DEPTH)
  ) u_gap_count (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  // A result only follows a cycle in which an item was taken or in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without an item in progress");

  // The longest gap never grows except when the line is restored.
  a_longest_falls: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != ST_SEED) |-> (cur_longest <= $past(cur_longest)))
    else $error("longest gap grew without a restore");

  // The reported length is always the tracked longest length.
  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (longest_gap == cur_longest))
    else $error("reported length differs from tracked longest");

  // A split always has its new cut strictly inside the found gap.
  a_split_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPLIT_RD) |-> (left_pos < pos && pos < right_pos))
    else $error("cut lies outside the gap being split");

endmodule

// ----- verif/longest_gap_after_cuts_core_tb.sv -----
// Self-checking testbench for the longest gap after cuts core.
module longest_gap_after_cuts_core_tb;
  import lgac_pkg::*;

  localparam int MAX_LEN = 4096;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  typedef struct packed {
    logic [LEN_W-1:0] longest_gap;
    logic             rejected;
  } gap_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [LEN_W-1:0] cut_position = '0;
  logic             line_length_wr = 1'b0;
  logic [LEN_W-1:0] line_length = '0;
  logic             busy;
  logic             done;
  logic [LEN_W-1:0] longest_gap;
  logic             rejected;

  longest_gap_after_cuts_core #(.MAX_LINE_LENGTH(MAX_LEN)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cut_position(cut_position),
    .line_length_wr(line_length_wr),
    .line_length(line_length),
    .done(done),
    .longest_gap(longest_gap),
    .rejected(rejected)
  );

  always #2 clk = ~clk;

  // Expected state of the line.
  bit          line_cut[MAX_LEN+1];
  int unsigned gaps_of_len[MAX_LEN+1];
  int unsigned longest_now;
  int unsigned line_len_now;
  int          placed_cuts[$];

  gap_result_t pending_gaps[$];
  gap_result_t oldest_gap;
  int          mismatches = 0;
  int          cuts_sent = 0;
  int          results_seen = 0;
  int          refusals_seen = 0;
  int          length_writes = 0;
  bit          idle_on = 1'b1;

  function automatic void restore_line(input int unsigned value);
    line_len_now = (value < 1) ? 1 : ((value > MAX_LEN) ? MAX_LEN : value);
    for (int i = 0; i <= MAX_LEN; i++) begin
      line_cut[i] = 1'b0;
      gaps_of_len[i] = 0;
    end
    gaps_of_len[line_len_now] = 1;
    longest_now = line_len_now;
    placed_cuts.delete();
  endfunction

  function automatic gap_result_t split_gap(input logic [LEN_W-1:0] pos);
    int unsigned p;
    int unsigned lo;
    int unsigned hi;
    gap_result_t r;
    p = pos;
    if (p == 0 || p >= line_len_now || line_cut[p]) begin
      r.longest_gap = LEN_W'(longest_now);
      r.rejected = 1'b1;
      return r;
    end
    lo = p - 1;
    while (lo > 0 && !line_cut[lo]) lo--;
    hi = p + 1;
    while (hi < line_len_now && !line_cut[hi]) hi++;
    if (gaps_of_len[hi - lo] > 0) gaps_of_len[hi - lo]--;
    gaps_of_len[p - lo]++;
    gaps_of_len[hi - p]++;
    line_cut[p] = 1'b1;
    placed_cuts.push_back(p);
    // Gaps only split, so the longest length can only walk downward.
    while (longest_now > 1 && gaps_of_len[longest_now] == 0) longest_now--;
    r.longest_gap = LEN_W'(longest_now);
    r.rejected = 1'b0;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pick_cut();
    int r;
    int p;
    r = $urandom_range(0, 99);
    p = 0;
    if (line_len_now > 1 && r < 82) begin
      repeat (4) begin
        p = $urandom_range(1, line_len_now - 1);
        if (!line_cut[p]) break;
      end
      return LEN_W'(p);
    end else if (r < 90 && placed_cuts.size() > 0) begin
      return LEN_W'(placed_cuts[$urandom_range(0, placed_cuts.size() - 1)]);
    end else if (r < 95) begin
      return $urandom_range(0, 1) ? LEN_W'(line_len_now) : '0;
    end
    return LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
  endfunction

  task automatic idle_burst();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 15);
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_cut(input logic [LEN_W-1:0] pos);
    @(negedge clk);
    start = 1'b1;
    cut_position = pos;
    do @(posedge clk); while (busy);
    pending_gaps.push_back(split_gap(pos));
    cuts_sent++;
    idle_burst();
  endtask

  // The length is only written with no cut in flight and the block idle.
  task automatic write_line_length(input logic [LEN_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    while (pending_gaps.size() != 0 || busy) @(negedge clk);
    line_length_wr = 1'b1;
    line_length = value;
    @(negedge clk);
    line_length_wr = 1'b0;
    restore_line(value);
    length_writes++;
  endtask

  task automatic test_directed();
    send_cut('0);
    send_cut(LEN_W'(4096));
    send_cut('1);
    send_cut(LEN_W'(1));
    send_cut(LEN_W'(4095));
    send_cut(LEN_W'(2048));
    send_cut(LEN_W'(2048));
    send_cut(LEN_W'(2));
    send_cut(LEN_W'(4094));
    send_cut(LEN_W'('h0aaa));
    send_cut(LEN_W'('h0555));
    // A zero length becomes a line of one with no valid cut.
    write_line_length('0);
    send_cut(LEN_W'(1));
    send_cut('0);
    write_line_length(LEN_W'(2));
    send_cut(LEN_W'(1));
    send_cut(LEN_W'(1));
    send_cut(LEN_W'(2));
    write_line_length('1);
    send_cut(LEN_W'(4095));
    send_cut(LEN_W'(1));
    write_line_length(LEN_W'(5000));
    send_cut(LEN_W'(4096));
    send_cut(LEN_W'(2000));
  endtask

  // Cutting every position of short lines drives the longest gap all the way to one.
  task automatic test_fill_short_lines();
    int lens[6] = '{3, 5, 17, 33, 64, 97};
    int order[$];
    int j;
    int t;
    foreach (lens[k]) begin
      write_line_length(LEN_W'(lens[k]));
      order.delete();
      for (int p = 1; p < lens[k]; p++) order.push_back(p);
      for (int i = order.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      foreach (order[i]) begin
        send_cut(LEN_W'(order[i]));
        if ($urandom_range(0, 7) == 0) send_cut(pick_cut());
      end
      send_cut(LEN_W'(1));
    end
  endtask

  task automatic test_random_lengths();
    logic [LEN_W-1:0] len;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: len = LEN_W'(4096);
        1: len = LEN_W'($urandom_range(1, 100));
        2: len = LEN_W'($urandom_range(101, 4096));
        default: len = LEN_W'($urandom_range(4097, (1 << LEN_W) - 1));
      endcase
      write_line_length(len);
      repeat (150) send_cut(pick_cut());
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    write_line_length(LEN_W'($urandom_range(200, 600)));
    repeat (250) send_cut(pick_cut());
  endtask

  task automatic note_error(input string msg);
    if (mismatches < 10) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (pending_gaps.size() == 0) begin
        note_error($sformatf("result with none expected: longest_gap %0d rejected %0b",
                             longest_gap, rejected));
      end else begin
        oldest_gap = pending_gaps.pop_front();
        if (oldest_gap.rejected) refusals_seen++;
        if (longest_gap !== oldest_gap.longest_gap)
          note_error($sformatf("longest_gap expected %0d got %0d",
                               oldest_gap.longest_gap, longest_gap));
        if (rejected !== oldest_gap.rejected)
          note_error($sformatf("rejected expected %0b got %0b",
                               oldest_gap.rejected, rejected));
      end
    end
  end

  initial begin
    restore_line(RESET_LENGTH);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_fill_short_lines();
    test_random_lengths();
    test_back_to_back();
    @(negedge clk);
    start = 1'b0;
    while (pending_gaps.size() != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    $display("Placed %0d cuts over %0d line lengths; %0d results checked, %0d refused.",
             cuts_sent, length_writes + 1, results_seen, refusals_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("Timed out with %0d results still expected.", pending_gaps.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
